[rtl/assert_macros.svh]
// Assertion macros for the RTL in this folder.
// No dependencies; the including module must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[rtl/cteb_pkg.sv]
// Types and codes for the cursor text edit buffer.
// No dependencies.
`timescale 1ns / 1ps

package cteb_pkg;

	// Command codes
	typedef enum logic [2:0] {
		OP_INSERT     = 3'd0,
		OP_MOVE_LEFT  = 3'd1,
		OP_MOVE_RIGHT = 3'd2,
		OP_DELETE     = 3'd3,
		OP_READ       = 3'd4
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_IGNORED = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// Controller states
	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	localparam int unsigned CharW   = 8;
	localparam int unsigned PosW    = 10;
	localparam int unsigned CountW  = 11;

endpackage

[rtl/cursor_text_edit_buffer.sv]
// Cursor text edit buffer: a gap buffer kept in two byte stacks in synchronous RAM.
// Depends on cteb_pkg and assert_macros.svh.
`timescale 1ns / 1ps

// One line of text with a cursor. Text left of the cursor sits in the left stack
// (oldest at the bottom), text right of it in the right stack (byte next to the
// cursor on top). A command is taken when start is high and busy is low; its
// result appears on the result ports for exactly one cycle with done high, in the
// cycle after the command is taken, and must be captured then. Each command first
// reads the stack RAMs into registered read data, then writes back (insert, cursor
// moves) and presents the result.
// The RAM contents are not cleared after reset; only the two stack counts and the controller state are.
module cursor_text_edit_buffer #(
	parameter int unsigned CAPACITY = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [2:0]                  op,
	input  logic [cteb_pkg::CharW-1:0]  char_in,
	input  logic [cteb_pkg::PosW-1:0]   position,
	output logic                        done,
	output logic [cteb_pkg::CharW-1:0]  char_out,
	output logic [cteb_pkg::CountW-1:0] text_length,
	output logic [cteb_pkg::CountW-1:0] cursor_pos,
	output logic [1:0]                  status
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned WB = (CW > cteb_pkg::CountW) ? CW : cteb_pkg::CountW;
	localparam int unsigned WW = WB + 1;

	// Stack storage
	logic [cteb_pkg::CharW-1:0] left_mem  [CAPACITY];
	logic [cteb_pkg::CharW-1:0] right_mem [CAPACITY];
	logic [cteb_pkg::CharW-1:0] left_rd_q;
	logic [cteb_pkg::CharW-1:0] right_rd_q;

	// Control state
	cteb_pkg::state_t state_q, state_d;
	logic [CW-1:0] lc_q;
	logic [CW-1:0] rc_q;

	// Stage one: command in flight
	cteb_pkg::op_t     op_s1;
	cteb_pkg::status_t status_s1;
	logic [cteb_pkg::CharW-1:0] ch_s1;
	logic [AW-1:0] wr_addr_s1;
	logic          wr_left_s1;
	logic          wr_right_s1;
	logic          rd_ok_s1;
	logic          rd_right_s1;

	// Decode of the incoming command
	logic              accept;
	logic [WW-1:0]     lcw, rcw, posw, total;
	logic [WW-1:0]     nxt_lc, nxt_rc;
	cteb_pkg::status_t st;
	logic [WW-1:0]     rd_left_addr, rd_right_addr, wr_addr;
	logic              wr_left, wr_right, rd_ok, rd_right;
	cteb_pkg::op_t     op_in;

	assign accept = start && !busy;
	assign lcw    = WW'(lc_q);
	assign rcw    = WW'(rc_q);
	assign posw   = WW'(position);
	assign total  = lcw + rcw;
	assign op_in  = cteb_pkg::op_t'(op);

	// Work out new counts, RAM addresses and status for the command
	always_comb begin
		nxt_lc        = lcw;
		nxt_rc        = rcw;
		st            = cteb_pkg::ST_DONE;
		rd_left_addr  = '0;
		rd_right_addr = '0;
		wr_addr       = '0;
		wr_left       = 1'b0;
		wr_right      = 1'b0;
		rd_ok         = 1'b0;
		rd_right      = 1'b0;
		unique case (op_in)
			cteb_pkg::OP_INSERT: begin
				if (total >= WW'(CAPACITY)) begin
					st = cteb_pkg::ST_FULL;
				end else begin
					wr_left = 1'b1;
					wr_addr = lcw;
					nxt_lc  = lcw + WW'(1);
				end
			end
			cteb_pkg::OP_MOVE_LEFT: begin
				if (lcw == '0) begin
					st = cteb_pkg::ST_IGNORED;
				end else begin
					rd_left_addr = lcw - WW'(1);
					wr_right     = 1'b1;
					wr_addr      = rcw;
					nxt_lc       = lcw - WW'(1);
					nxt_rc       = rcw + WW'(1);
				end
			end
			cteb_pkg::OP_MOVE_RIGHT: begin
				if (rcw == '0) begin
					st = cteb_pkg::ST_IGNORED;
				end else begin
					rd_right_addr = rcw - WW'(1);
					wr_left       = 1'b1;
					wr_addr       = lcw;
					nxt_lc        = lcw + WW'(1);
					nxt_rc        = rcw - WW'(1);
				end
			end
			cteb_pkg::OP_DELETE: begin
				if (lcw == '0) begin
					st = cteb_pkg::ST_IGNORED;
				end else begin
					nxt_lc = lcw - WW'(1);
				end
			end
			cteb_pkg::OP_READ: begin
				if (posw < lcw) begin
					rd_left_addr = posw;
					rd_ok        = 1'b1;
				end else if (posw < total) begin
					rd_right_addr = total - WW'(1) - posw;
					rd_ok         = 1'b1;
					rd_right      = 1'b1;
				end else begin
					st = cteb_pkg::ST_IGNORED;
				end
			end
			default: begin
				st = cteb_pkg::ST_IGNORED;
			end
		endcase
	end

	// Advance the controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cteb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cteb_pkg::S_IDLE: begin
				if (start) begin
					state_d = cteb_pkg::S_EXEC;
				end
			end
			cteb_pkg::S_EXEC: begin
				state_d = cteb_pkg::S_IDLE;
			end
			default: begin
				state_d = cteb_pkg::S_IDLE;
			end
		endcase
	end

	assign busy = (state_q == cteb_pkg::S_EXEC);

	// Update the stack counts when a transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q <= '0;
			rc_q <= '0;
		end else if (accept) begin
			lc_q <= nxt_lc[CW-1:0];
			rc_q <= nxt_rc[CW-1:0];
		end
	end

	// Hold the command for the write-back cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= op_in;
			status_s1   <= st;
			ch_s1       <= char_in;
			wr_addr_s1  <= wr_addr[AW-1:0];
			wr_left_s1  <= wr_left;
			wr_right_s1 <= wr_right;
			rd_ok_s1    <= rd_ok;
			rd_right_s1 <= rd_right;
		end
	end

	// Left stack RAM: read on accept, write back in the execute cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			left_rd_q <= left_mem[rd_left_addr[AW-1:0]];
		end
		if (busy && wr_left_s1) begin
			left_mem[wr_addr_s1] <= (op_s1 == cteb_pkg::OP_INSERT) ? ch_s1 : right_rd_q;
		end
	end

	// Right stack RAM: read on accept, write back in the execute cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			right_rd_q <= right_mem[rd_right_addr[AW-1:0]];
		end
		if (busy && wr_right_s1) begin
			right_mem[wr_addr_s1] <= left_rd_q;
		end
	end

	// Present the result during the execute cycle
	logic [WW-1:0] len_w;
	assign len_w       = lcw + rcw;
	assign done        = busy;
	assign char_out    = !rd_ok_s1 ? '0 : (rd_right_s1 ? right_rd_q : left_rd_q);
	assign text_length = len_w[cteb_pkg::CountW-1:0];
	assign cursor_pos  = lcw[cteb_pkg::CountW-1:0];
	assign status      = status_s1;

	// Checks
	`include "assert_macros.svh"

	`ASSERT_CLK(a_result_follows, (start && !busy) |=> done, "no result after a taken command")
	`ASSERT_CLK(a_single_result, done |=> !done, "result held longer than one cycle")
	`ASSERT_NEVER(a_over_capacity, len_w > WW'(CAPACITY), "text longer than capacity")
	`ASSERT_NEVER(a_full_on_insert, done && status_s1 == cteb_pkg::ST_FULL && op_s1 != cteb_pkg::OP_INSERT, "full status on a non-insert command")

endmodule
